// ===== design/normal_cdf_approx_defines.svh =====
// Assertion macros shared by the normal cdf block.
`ifndef NORMAL_CDF_APPROX_DEFINES_SVH
`define NORMAL_CDF_APPROX_DEFINES_SVH

`ifndef ASSERT_OFF
// Property must hold at every clock edge outside reset.
`define NCDF_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("normal_cdf_approx: property failed");
// Expression must never be true outside reset.
`define NCDF_ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("normal_cdf_approx: forbidden condition");
`else
`define NCDF_ASSERT(label, clk, rst, prop)
`define NCDF_ASSERT_NEVER(label, clk, rst, expr)
`endif

`endif

// ===== design/ncdf_pkg.sv =====
`timescale 1ns / 1ps
package ncdf_pkg;

   // Q30 constants of the erf approximation
   localparam logic [30:0] ONE_Q = 31'h4000_0000;
   localparam logic [29:0] INV_ROOT2 = 30'd759250125;
   localparam logic [28:0] COEF_P = 29'd351748265;
   localparam logic signed [33:0] COEF_A1 = 34'sd273621191;
   localparam logic signed [33:0] COEF_A2 = -34'sd305476044;
   localparam logic signed [33:0] COEF_A3 = 34'sd1526231383;
   localparam logic signed [33:0] COEF_A4 = -34'sd1560310108;
   localparam logic signed [33:0] COEF_A5 = 34'sd1139675401;

   localparam int EXP_STEPS = 14;
   localparam int DIV_STEPS = 31;
   localparam int HORNER_STEPS = 5;

   // Start remainder of 2^60 / den once the leading dividend bits are consumed
   localparam logic [31:0] DIV_SEED = 32'h2000_0000;

   typedef struct packed {
      logic        neg;
      logic        sat;
      logic [31:0] den;
      logic [33:0] w;
   } front_type;

   typedef struct packed {
      logic        neg;
      logic        sat;
      logic [31:0] den;
      logic [33:0] w;
      logic [30:0] e;
   } exp_type;

   typedef struct packed {
      logic        neg;
      logic        sat;
      logic [30:0] t;
      logic [30:0] e;
   } div_type;

   typedef struct packed {
      logic        neg;
      logic        sat;
      logic [30:0] tp;
      logic [30:0] e;
   } poly_type;

   // exp(-2^k) in Q30, k = 3 down to -10
   function automatic logic [29:0] exp_factor(input logic [3:0] idx);
      logic [29:0] f;
      unique case (idx)
         4'd0:    f = 30'd360200;
         4'd1:    f = 30'd19666267;
         4'd2:    f = 30'd145315154;
         4'd3:    f = 30'd395007542;
         4'd4:    f = 30'd651257337;
         4'd5:    f = 30'd836230973;
         4'd6:    f = 30'd947573834;
         4'd7:    f = 30'd1008687096;
         4'd8:    f = 30'd1040706261;
         4'd9:    f = 30'd1057095000;
         4'd10:   f = 30'd1065385899;
         4'd11:   f = 30'd1069555701;
         4'd12:   f = 30'd1071646719;
         4'd13:   f = 30'd1072693760;
         default: f = 30'd0;
      endcase
      return f;
   endfunction

   // Constant added after each Horner product
   function automatic logic signed [33:0] horner_coef(input logic [2:0] j);
      logic signed [33:0] c;
      unique case (j)
         3'd0:    c = COEF_A4;
         3'd1:    c = COEF_A3;
         3'd2:    c = COEF_A2;
         3'd3:    c = COEF_A1;
         default: c = 34'sd0;
      endcase
      return c;
   endfunction

endpackage

// ===== design/ncdf_front.sv =====
`timescale 1ns / 1ps
module ncdf_front #(
   parameter int ARG_FRAC_BITS = 11
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  logic signed [15:0]  arg_value,
   output logic                out_valid,
   output ncdf_pkg::front_type out_side
);
   import ncdf_pkg::*;

   localparam int PW = (ARG_FRAC_BITS + 33 > 47) ? ARG_FRAC_BITS + 33 : 47;

   logic [15:0]   raw_ff;
   logic [16:0]   mag;
   logic [PW-1:0] zprod_in, zprod_ff;
   logic [31:0]   z;
   logic          sat;
   logic [60:0]   pz_in, pz_ff;
   logic [63:0]   zz_in, zz_ff;
   logic [31:0]   den_in, den_ff;
   logic [3:0]    v_ff;
   logic [3:0]    neg_ff;
   logic [2:1]    sat_ff;
   logic [33:0]   w_ff;

   // Magnitude, with the most negative code taken as 32768
   assign mag = neg_ff[0] ? (17'h10000 - {1'b0, raw_ff}) : {1'b0, raw_ff};
   assign zprod_in = PW'(mag) * PW'(INV_ROOT2);

   // Scale down to Q30 and flag the far tail
   assign z = zprod_ff[ARG_FRAC_BITS +: 32];
   assign sat = |zprod_ff[PW-1:ARG_FRAC_BITS+32];
   assign pz_in = 61'(z) * 61'(COEF_P);
   assign zz_in = 64'(z) * 64'(z);

   assign den_in = 32'(ONE_Q) + {1'b0, pz_ff[60:30]};

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[2:0], in_valid};
      end
   end

   // Advance payload
   always_ff @(posedge clock) begin
      if (en) begin
         raw_ff   <= arg_value;
         neg_ff   <= {neg_ff[2:0], arg_value[15]};
         zprod_ff <= zprod_in;
         pz_ff    <= pz_in;
         zz_ff    <= zz_in;
         sat_ff   <= {sat_ff[1], sat};
         den_ff   <= den_in;
         w_ff     <= zz_ff[63:30];
      end
   end

   assign out_valid    = v_ff[3];
   assign out_side.neg = neg_ff[3];
   assign out_side.sat = sat_ff[2];
   assign out_side.den = den_ff;
   assign out_side.w   = w_ff;

endmodule

// ===== design/ncdf_exp.sv =====
`timescale 1ns / 1ps
module ncdf_exp (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  ncdf_pkg::front_type in_side,
   output logic                out_valid,
   output ncdf_pkg::exp_type   out_side
);
   import ncdf_pkg::*;

   localparam int NS = EXP_STEPS + 1;

   logic [30:0] acc_in [NS];
   logic [30:0] acc_ff [NS];
   front_type   side_ff [NS];
   logic [NS-1:0] v_ff;

   // One factor per set bit of w, then the linear residual step
   always_comb begin
      logic [30:0] a_src;
      logic [30:0] f_src;
      logic        take;
      logic [60:0] prod;
      front_type   s_src;
      for (int k = 0; k < NS; k++) begin
         a_src = (k == 0) ? ONE_Q : acc_ff[(k == 0) ? 0 : k - 1];
         s_src = (k == 0) ? in_side : side_ff[(k == 0) ? 0 : k - 1];
         if (k < EXP_STEPS) begin
            f_src = {1'b0, exp_factor(4'(k))};
            take  = s_src.w[33 - k];
         end else begin
            f_src = ONE_Q - {11'd0, s_src.w[19:0]};
            take  = 1'b1;
         end
         prod = 61'(a_src) * 61'(f_src);
         acc_in[k] = take ? prod[60:30] : a_src;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[NS-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < NS; k++) begin
            acc_ff[k]  <= acc_in[k];
            side_ff[k] <= (k == 0) ? in_side : side_ff[(k == 0) ? 0 : k - 1];
         end
      end
   end

   assign out_valid    = v_ff[NS-1];
   assign out_side.neg = side_ff[NS-1].neg;
   assign out_side.sat = side_ff[NS-1].sat;
   assign out_side.den = side_ff[NS-1].den;
   assign out_side.w   = side_ff[NS-1].w;
   assign out_side.e   = acc_ff[NS-1];

endmodule

// ===== design/ncdf_div.sv =====
`timescale 1ns / 1ps
module ncdf_div (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  ncdf_pkg::exp_type in_side,
   output logic              out_valid,
   output ncdf_pkg::div_type out_side
);
   import ncdf_pkg::*;

   logic [31:0] rem_in [DIV_STEPS];
   logic [31:0] rem_ff [DIV_STEPS];
   logic [30:0] quo_in [DIV_STEPS];
   logic [30:0] quo_ff [DIV_STEPS];
   exp_type     side_ff [DIV_STEPS];
   logic [DIV_STEPS-1:0] v_ff;

   // Restoring division of 2^60 by den, one quotient bit per stage
   always_comb begin
      logic [31:0] r_src;
      logic [30:0] q_src;
      logic [32:0] r2;
      logic [32:0] dv;
      logic        ge;
      for (int k = 0; k < DIV_STEPS; k++) begin
         r_src = (k == 0) ? DIV_SEED : rem_ff[(k == 0) ? 0 : k - 1];
         q_src = (k == 0) ? 31'd0 : quo_ff[(k == 0) ? 0 : k - 1];
         dv    = (k == 0) ? {1'b0, in_side.den} : {1'b0, side_ff[(k == 0) ? 0 : k - 1].den};
         r2    = {r_src, 1'b0};
         ge    = (r2 >= dv);
         rem_in[k] = ge ? 32'(r2 - dv) : r2[31:0];
         quo_in[k] = {q_src[29:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[DIV_STEPS-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < DIV_STEPS; k++) begin
            rem_ff[k]  <= rem_in[k];
            quo_ff[k]  <= quo_in[k];
            side_ff[k] <= (k == 0) ? in_side : side_ff[(k == 0) ? 0 : k - 1];
         end
      end
   end

   assign out_valid    = v_ff[DIV_STEPS-1];
   assign out_side.neg = side_ff[DIV_STEPS-1].neg;
   assign out_side.sat = side_ff[DIV_STEPS-1].sat;
   assign out_side.t   = quo_ff[DIV_STEPS-1];
   assign out_side.e   = side_ff[DIV_STEPS-1].e;

endmodule

// ===== design/ncdf_horner.sv =====
`timescale 1ns / 1ps
module ncdf_horner (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  ncdf_pkg::div_type  in_side,
   output logic               out_valid,
   output ncdf_pkg::poly_type out_side
);
   import ncdf_pkg::*;

   localparam int NS = 2 * HORNER_STEPS;

   logic [63:0]        prod_in [HORNER_STEPS];
   logic [63:0]        prod_ff [HORNER_STEPS];
   logic               psgn_in [HORNER_STEPS];
   logic               psgn_ff [HORNER_STEPS];
   logic signed [33:0] acc_in  [HORNER_STEPS];
   logic signed [33:0] acc_ff  [HORNER_STEPS];
   div_type            side_ff [NS];
   logic [NS-1:0]      v_ff;

   // Multiply stage: magnitude of acc times t
   always_comb begin
      logic signed [33:0] a_src;
      logic [32:0]        mag;
      logic [30:0]        t_src;
      for (int j = 0; j < HORNER_STEPS; j++) begin
         a_src = (j == 0) ? COEF_A5 : acc_ff[(j == 0) ? 0 : j - 1];
         t_src = (j == 0) ? in_side.t : side_ff[(j == 0) ? 0 : 2 * j - 1].t;
         psgn_in[j] = a_src[33];
         mag = a_src[33] ? 33'(-a_src) : a_src[32:0];
         prod_in[j] = 64'(mag) * 64'(t_src);
      end
   end

   // Add stage: restore sign, truncated toward zero, add the next coefficient; the last clamps to [0, ONE_Q]
   always_comb begin
      logic signed [33:0] p;
      logic signed [33:0] s;
      for (int j = 0; j < HORNER_STEPS; j++) begin
         p = $signed(prod_ff[j][63:30]);
         s = (psgn_ff[j] ? -p : p) + horner_coef(3'(j));
         if (j == HORNER_STEPS - 1) begin
            if (s < 34'sd0) begin
               s = 34'sd0;
            end else if (s > $signed(34'(ONE_Q))) begin
               s = $signed(34'(ONE_Q));
            end
         end
         acc_in[j] = s;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[NS-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j < HORNER_STEPS; j++) begin
            prod_ff[j] <= prod_in[j];
            psgn_ff[j] <= psgn_in[j];
            acc_ff[j]  <= acc_in[j];
         end
         for (int k = 0; k < NS; k++) begin
            side_ff[k] <= (k == 0) ? in_side : side_ff[(k == 0) ? 0 : k - 1];
         end
      end
   end

   assign out_valid    = v_ff[NS-1];
   assign out_side.neg = side_ff[NS-1].neg;
   assign out_side.sat = side_ff[NS-1].sat;
   assign out_side.tp  = acc_ff[HORNER_STEPS-1][30:0];
   assign out_side.e   = side_ff[NS-1].e;

endmodule

// ===== design/normal_cdf_approx.sv =====
`timescale 1ns / 1ps
// Data path: front, exp, quotient, Horner, product and rounding registers, output buffer.
// Throughput: one word per cycle while the buffer has room; all stages share one enable.
// The enable follows a two-word output buffer, so a new word enters while one result waits.
// The longest chain is the 31-stage quotient pipeline for t = 1/(1 + p*z).
// Reset (synchronous, active high) clears all valid bits and the output buffer.
`include "normal_cdf_approx_defines.svh"
module normal_cdf_approx #(
   parameter int ARG_FRAC_BITS = 11,
   parameter int OUT_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [15:0]                          req_tdata,  // [15:0] arg_value
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [((OUT_BITS + 7) / 8) * 8 - 1:0] rsp_tdata   // [OUT_BITS-1:0] cdf_value
);
   import ncdf_pkg::*;

   localparam int TW = ((OUT_BITS + 7) / 8) * 8;
   localparam int SW = OUT_BITS + 33;
   localparam logic [OUT_BITS-1:0] MAXV = '1;

   logic      en;
   logic      front_v, exp_v, div_v, poly_v;
   front_type front_s;
   exp_type   exp_s;
   div_type   div_s;
   poly_type  poly_s;

   logic [61:0]         fprod_ff;
   logic                f1_v_ff, f1_neg_ff, f1_sat_ff;
   logic [31:0]         q;
   logic [31:0]         c;
   logic [SW-1:0]       sum;
   logic [OUT_BITS+1:0] res;
   logic [OUT_BITS-1:0] cdf_in, cdf_ff;
   logic                f2_v_ff;

   logic [OUT_BITS-1:0] head_ff, tail_ff;
   logic [1:0]          cnt_ff;
   logic                push, pop;

   // Whole pipeline moves unless the output buffer is full
   assign en = (cnt_ff != 2'd2);
   assign req_tready = en;

   ncdf_front #(.ARG_FRAC_BITS(ARG_FRAC_BITS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_tvalid),
      .arg_value ($signed(req_tdata)),
      .out_valid (front_v),
      .out_side  (front_s)
   );

   ncdf_exp u_exp (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (front_v),
      .in_side   (front_s),
      .out_valid (exp_v),
      .out_side  (exp_s)
   );

   ncdf_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (exp_v),
      .in_side   (exp_s),
      .out_valid (div_v),
      .out_side  (div_s)
   );

   ncdf_horner u_horner (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (div_v),
      .in_side   (div_s),
      .out_valid (poly_v),
      .out_side  (poly_s)
   );

   // Fold the sign back and round to the output width
   assign q   = fprod_ff[61:30];
   assign c   = f1_neg_ff ? q : (32'h8000_0000 - q);
   assign sum = (SW'(c) << OUT_BITS) + SW'(ONE_Q);
   assign res = sum[SW-1:31];

   always_comb begin
      if (f1_sat_ff) begin
         cdf_in = f1_neg_ff ? '0 : MAXV;
      end else if (|res[OUT_BITS+1:OUT_BITS]) begin
         cdf_in = MAXV;
      end else begin
         cdf_in = res[OUT_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_v_ff <= 1'b0;
         f2_v_ff <= 1'b0;
      end else if (en) begin
         f1_v_ff <= poly_v;
         f2_v_ff <= f1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         fprod_ff  <= 62'(poly_s.tp) * 62'(poly_s.e);
         f1_neg_ff <= poly_s.neg;
         f1_sat_ff <= poly_s.sat;
         cdf_ff    <= cdf_in;
      end
   end

   // Two-word output buffer
   assign push = en && f2_v_ff;
   assign pop  = rsp_tvalid && rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else if (push && !pop) begin
         cnt_ff <= cnt_ff + 2'd1;
      end else if (pop && !push) begin
         cnt_ff <= cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push && !pop) begin
         if (cnt_ff == 2'd0) begin
            head_ff <= cdf_ff;
         end else begin
            tail_ff <= cdf_ff;
         end
      end else if (pop && !push) begin
         head_ff <= tail_ff;
      end else if (pop && push) begin
         head_ff <= cdf_ff;
      end
   end

   assign rsp_tvalid = (cnt_ff != 2'd0);
   assign rsp_tdata  = TW'(head_ff);

   `NCDF_ASSERT_NEVER(a_cnt_legal, clock, reset, cnt_ff == 2'd3)
   `NCDF_ASSERT(a_full_not_empty, clock, reset, (cnt_ff == 2'd2) |=> (cnt_ff != 2'd0))
   `NCDF_ASSERT(a_last_drains, clock, reset, (pop && !push && cnt_ff == 2'd1) |=> !rsp_tvalid)

endmodule
